// ===== rtl/core/csbr_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and helpers for the camera smooth and basis rotate core
package csbr_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;
    localparam int RATE_W     = 4;
    localparam int UP_W       = 18;
    localparam int STEP_W     = 16;
    localparam int COORD_W    = 32;
    localparam int GAIN_W     = 17;
    localparam int OPND_W     = 33;
    localparam int PROD_W     = 66;
    localparam int ACC_W      = 68;
    localparam int MAG_W      = 49;
    localparam int UNIT_BITS  = 30;
    localparam int GAIN_SHIFT = 16;

    localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;

    localparam logic CMD_MOVE   = 1'b0;
    localparam logic CMD_ROTATE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SMOOTH_RATE = 2'd0,
        CFG_UP_X        = 2'd1,
        CFG_UP_Y        = 2'd2,
        CFG_UP_Z        = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MV_MUL,
        ST_MV_UPD,
        ST_NM_MAX,
        ST_NM_SHIFT,
        ST_NM_SQ_MUL,
        ST_NM_SQ_ACC,
        ST_SQ_STEP,
        ST_DV_INIT,
        ST_DV_STEP,
        ST_DV_DONE,
        ST_DOT_MUL,
        ST_DOT_ACC,
        ST_DOT_DONE,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        PH_CR,
        PH_U,
        PH_OUT
    } phase_t;

    // next component index modulo three
    function automatic logic [1:0] mod3_inc(input logic [1:0] k);
        logic [1:0] r;
        case (k)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp32(input logic signed [ACC_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > $signed({{(ACC_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}}))
            r = {1'b0, {(COORD_W-1){1'b1}}};
        else if (v < $signed({{(ACC_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}}))
            r = {1'b1, {(COORD_W-1){1'b0}}};
        else
            r = v[COORD_W-1:0];
        return r;
    endfunction

endpackage

// ===== rtl/core/csbr_cfg_if.sv =====
`timescale 1ns / 1ps
// configuration write channel
interface csbr_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [csbr_pkg::CFG_IDX_W-1:0]     index;
    logic [csbr_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/csbr_in_if.sv =====
`timescale 1ns / 1ps
// input item channel
interface csbr_in_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   command;
    logic [csbr_pkg::STEP_W-1:0]            step_time;
    logic signed [csbr_pkg::COORD_W-1:0]    cam_target_x;
    logic signed [csbr_pkg::COORD_W-1:0]    cam_target_y;
    logic signed [csbr_pkg::COORD_W-1:0]    cam_target_z;
    logic signed [csbr_pkg::COORD_W-1:0]    look_target_x;
    logic signed [csbr_pkg::COORD_W-1:0]    look_target_y;
    logic signed [csbr_pkg::COORD_W-1:0]    look_target_z;
    logic signed [csbr_pkg::COORD_W-1:0]    dir_x;
    logic signed [csbr_pkg::COORD_W-1:0]    dir_y;
    logic signed [csbr_pkg::COORD_W-1:0]    dir_z;

    modport source (output valid, command, step_time, cam_target_x, cam_target_y,
                    cam_target_z, look_target_x, look_target_y, look_target_z,
                    dir_x, dir_y, dir_z, input ready);
    modport sink   (input valid, command, step_time, cam_target_x, cam_target_y,
                    cam_target_z, look_target_x, look_target_y, look_target_z,
                    dir_x, dir_y, dir_z, output ready);
endinterface

// ===== rtl/core/csbr_out_if.sv =====
`timescale 1ns / 1ps
// result item channel
interface csbr_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [csbr_pkg::COORD_W-1:0]    rotated_x;
    logic signed [csbr_pkg::COORD_W-1:0]    rotated_y;
    logic signed [csbr_pkg::COORD_W-1:0]    rotated_z;

    modport source (output valid, rotated_x, rotated_y, rotated_z, input ready);
    modport sink   (input valid, rotated_x, rotated_y, rotated_z, output ready);
endinterface

// ===== rtl/core/camera_smooth_and_basis_rotate_core.sv =====
`timescale 1ns / 1ps
// smoothed look-at camera: easing of camera and look-at point, basis rotation of a direction
//
// channel    modport  handshake      payload
// cfg        sink     valid/ready    index (0 smooth_rate, 1..3 up x/y/z), data
// request    sink     valid/ready    command, step_time, cam/look targets, dir
// response   source   valid/ready    rotated_x, rotated_y, rotated_z (rotate items only)
//
// one item at a time; request.ready is high only while the sequencer is idle
// move item: for each of the six components, one shared 33x33 multiply then an update step
// rotate item: the bit-serial square root (32 steps) and the restoring divider
// (31 steps per component) each run for two normalizes
// result sits in an output register, so a stalled response does not block a move item
// reset clears camera (0,0,0), look-at point (0,1.0,0), smooth_rate 5, up (0,0,1.0)
// cfg is always ready; writes are expected only while no item is in flight
module camera_smooth_and_basis_rotate_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    csbr_cfg_if.sink            cfg,
    csbr_in_if.sink             request,
    csbr_out_if.source          response
);

    localparam int COORD_W   = csbr_pkg::COORD_W;
    localparam int ACC_W     = csbr_pkg::ACC_W;
    localparam int PROD_W    = csbr_pkg::PROD_W;
    localparam int OPND_W    = csbr_pkg::OPND_W;
    localparam int MAG_W     = csbr_pkg::MAG_W;
    localparam int UP_W      = csbr_pkg::UP_W;
    localparam int GAIN_W    = csbr_pkg::GAIN_W;
    localparam int RATE_W    = csbr_pkg::RATE_W;
    localparam int UNIT_BITS = csbr_pkg::UNIT_BITS;

    localparam logic signed [COORD_W-1:0] LOOK_Y_RESET = COORD_W'(64'd1 << FRAC_BITS);
    localparam logic signed [ACC_W-1:0]   HALF_UNIT    = ACC_W'(64'd1 << (UNIT_BITS - 1));
    localparam logic signed [ACC_W-1:0]   HALF_GAIN    =
        ACC_W'(64'd1 << (csbr_pkg::GAIN_SHIFT - 1));

    // control state
    csbr_pkg::state_t   state_reg, state_next;
    csbr_pkg::phase_t   phase_reg;
    logic               nsel_reg;       // normalize target: 0 view axis, 1 side axis
    logic [2:0]         mv_idx_reg;     // 0..2 camera, 3..5 look-at point
    logic [1:0]         k_reg;          // component
    logic [1:0]         t_reg;          // term within a dot product
    logic [4:0]         dv_bit_reg;     // quotient bit under trial
    logic               out_valid_reg;

    // kept state and configuration
    logic signed [COORD_W-1:0]  cam_reg  [3];
    logic signed [COORD_W-1:0]  look_reg [3];
    logic [RATE_W-1:0]          rate_reg;
    logic signed [UP_W-1:0]     up_reg   [3];

    // item payload and working values
    logic signed [COORD_W-1:0]  tgt_c_reg [3];
    logic signed [COORD_W-1:0]  tgt_l_reg [3];
    logic signed [COORD_W-1:0]  dir_reg   [3];
    logic [GAIN_W-1:0]          gain_reg;
    logic [MAG_W-1:0]           mag_reg   [3];
    logic                       neg_reg   [3];
    logic [MAG_W-1:0]           m_reg;
    logic signed [COORD_W-1:0]  f_reg     [3];
    logic signed [COORD_W-1:0]  s_reg     [3];
    logic signed [COORD_W-1:0]  u_reg     [3];
    logic signed [COORD_W-1:0]  rot_reg   [3];
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic [61:0]                sq_x_reg;
    logic [63:0]                sq_res_reg;
    logic [63:0]                sq_bit_reg;
    logic [61:0]                dv_rem_reg;
    logic [30:0]                dv_q_reg;
    logic signed [COORD_W-1:0]  out_x_reg, out_y_reg, out_z_reg;

    // combinational helpers
    logic                       in_fire;
    logic                       out_free;
    logic [1:0]                 k1, k2;
    logic signed [COORD_W-1:0]  mv_tgt, mv_pos, mv_new;
    logic signed [ACC_W-1:0]    mv_sum;
    logic signed [OPND_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]   mul_p;
    logic [MAG_W-1:0]           mag_max;
    logic                       t_last, dot_sub;
    logic signed [ACC_W-1:0]    prod_ext, acc_add, acc_rnd;
    logic [MAG_W-1:0]           acc_mag;
    logic [63:0]                sq_trial, sq_res_next;
    logic                       sq_ge;
    logic [30:0]                len;
    logic [61:0]                dv_trial;
    logic signed [COORD_W-1:0]  dv_val;
    logic signed [33:0]         diff [3];
    logic [19:0]                gain_raw;

    assign in_fire  = request.valid && request.ready;
    assign out_free = !out_valid_reg || response.ready;
    assign k1       = csbr_pkg::mod3_inc(k_reg);
    assign k2       = csbr_pkg::mod3_inc(k1);
    assign len      = sq_res_reg[30:0];
    assign mul_p    = mul_a * mul_b;
    assign gain_raw = rate_reg * request.step_time;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff[i] = 34'(cam_reg[i]) - 34'(look_reg[i]);
        end
    end

    // easing operands
    always_comb
    begin
        case (mv_idx_reg)
            3'd0:    begin mv_tgt = tgt_c_reg[0]; mv_pos = cam_reg[0];  end
            3'd1:    begin mv_tgt = tgt_c_reg[1]; mv_pos = cam_reg[1];  end
            3'd2:    begin mv_tgt = tgt_c_reg[2]; mv_pos = cam_reg[2];  end
            3'd3:    begin mv_tgt = tgt_l_reg[0]; mv_pos = look_reg[0]; end
            3'd4:    begin mv_tgt = tgt_l_reg[1]; mv_pos = look_reg[1]; end
            default: begin mv_tgt = tgt_l_reg[2]; mv_pos = look_reg[2]; end
        endcase
        mv_sum = ACC_W'(mv_pos) + ((ACC_W'(prod_reg) + HALF_GAIN) >>> csbr_pkg::GAIN_SHIFT);
        mv_new = csbr_pkg::clamp32(mv_sum);
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            csbr_pkg::ST_MV_MUL:
            begin
                mul_a = OPND_W'(mv_tgt) - OPND_W'(mv_pos);
                mul_b = $signed({{(OPND_W-GAIN_W){1'b0}}, gain_reg});
            end
            csbr_pkg::ST_NM_SQ_MUL:
            begin
                mul_a = $signed({3'b0, mag_reg[k_reg][29:0]});
                mul_b = $signed({3'b0, mag_reg[k_reg][29:0]});
            end
            csbr_pkg::ST_DOT_MUL:
            begin
                case (phase_reg)
                    csbr_pkg::PH_CR:
                    begin
                        mul_a = (t_reg == 2'd0) ? OPND_W'(up_reg[k1]) : OPND_W'(up_reg[k2]);
                        mul_b = (t_reg == 2'd0) ? OPND_W'(f_reg[k2])  : OPND_W'(f_reg[k1]);
                    end
                    csbr_pkg::PH_U:
                    begin
                        mul_a = (t_reg == 2'd0) ? OPND_W'(f_reg[k1]) : OPND_W'(f_reg[k2]);
                        mul_b = (t_reg == 2'd0) ? OPND_W'(s_reg[k2]) : OPND_W'(s_reg[k1]);
                    end
                    default:
                    begin
                        case (t_reg)
                            2'd0:
                            begin
                                mul_a = OPND_W'(dir_reg[0]);
                                mul_b = OPND_W'(s_reg[k_reg]);
                            end
                            2'd1:
                            begin
                                mul_a = OPND_W'(dir_reg[1]);
                                mul_b = OPND_W'(u_reg[k_reg]);
                            end
                            default:
                            begin
                                mul_a = OPND_W'(dir_reg[2]);
                                mul_b = OPND_W'(f_reg[k_reg]);
                            end
                        endcase
                    end
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // magnitude maximum, accumulate, round, square root and divide steps
    always_comb
    begin
        mag_max = mag_reg[0];
        if (mag_reg[1] > mag_max)
            mag_max = mag_reg[1];
        if (mag_reg[2] > mag_max)
            mag_max = mag_reg[2];

        t_last   = (phase_reg == csbr_pkg::PH_OUT) ? (t_reg == 2'd2) : (t_reg == 2'd1);
        dot_sub  = (phase_reg != csbr_pkg::PH_OUT) && (t_reg == 2'd1);
        prod_ext = ACC_W'(prod_reg);
        acc_add  = dot_sub ? (acc_reg - prod_ext) : (acc_reg + prod_ext);
        acc_rnd  = (acc_reg + HALF_UNIT) >>> UNIT_BITS;
        acc_mag  = acc_reg[ACC_W-1] ? MAG_W'(-acc_reg) : MAG_W'(acc_reg);

        sq_trial = sq_res_reg + sq_bit_reg;
        sq_ge    = {2'b0, sq_x_reg} >= sq_trial;
        sq_res_next = sq_ge ? ((sq_res_reg >> 1) + sq_bit_reg) : (sq_res_reg >> 1);

        dv_trial = {31'b0, len} << dv_bit_reg;
        dv_val   = neg_reg[k_reg] ? -$signed({1'b0, dv_q_reg}) : $signed({1'b0, dv_q_reg});
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            csbr_pkg::ST_IDLE:
                if (request.valid)
                    state_next = (request.command == csbr_pkg::CMD_ROTATE) ?
                                 csbr_pkg::ST_NM_MAX : csbr_pkg::ST_MV_MUL;
            csbr_pkg::ST_MV_MUL:
                state_next = csbr_pkg::ST_MV_UPD;
            csbr_pkg::ST_MV_UPD:
                state_next = (mv_idx_reg == 3'd5) ? csbr_pkg::ST_IDLE : csbr_pkg::ST_MV_MUL;
            csbr_pkg::ST_NM_MAX:
                state_next = (mag_max == '0) ? csbr_pkg::ST_DOT_MUL : csbr_pkg::ST_NM_SHIFT;
            csbr_pkg::ST_NM_SHIFT:
                if (m_reg[MAG_W-1:UNIT_BITS] == '0 && m_reg[UNIT_BITS-1])
                    state_next = csbr_pkg::ST_NM_SQ_MUL;
            csbr_pkg::ST_NM_SQ_MUL:
                state_next = csbr_pkg::ST_NM_SQ_ACC;
            csbr_pkg::ST_NM_SQ_ACC:
                state_next = (k_reg == 2'd2) ? csbr_pkg::ST_SQ_STEP : csbr_pkg::ST_NM_SQ_MUL;
            csbr_pkg::ST_SQ_STEP:
                if (sq_bit_reg[0])
                    state_next = csbr_pkg::ST_DV_INIT;
            csbr_pkg::ST_DV_INIT:
                state_next = csbr_pkg::ST_DV_STEP;
            csbr_pkg::ST_DV_STEP:
                if (dv_bit_reg == '0)
                    state_next = csbr_pkg::ST_DV_DONE;
            csbr_pkg::ST_DV_DONE:
                state_next = (k_reg == 2'd2) ? csbr_pkg::ST_DOT_MUL : csbr_pkg::ST_DV_INIT;
            csbr_pkg::ST_DOT_MUL:
                state_next = csbr_pkg::ST_DOT_ACC;
            csbr_pkg::ST_DOT_ACC:
                state_next = t_last ? csbr_pkg::ST_DOT_DONE : csbr_pkg::ST_DOT_MUL;
            csbr_pkg::ST_DOT_DONE:
                if (k_reg != 2'd2)
                    state_next = csbr_pkg::ST_DOT_MUL;
                else
                begin
                    case (phase_reg)
                        csbr_pkg::PH_CR: state_next = csbr_pkg::ST_NM_MAX;
                        csbr_pkg::PH_U:  state_next = csbr_pkg::ST_DOT_MUL;
                        default:         state_next = csbr_pkg::ST_EMIT;
                    endcase
                end
            csbr_pkg::ST_EMIT:
                if (out_free)
                    state_next = csbr_pkg::ST_IDLE;
            default:
                state_next = csbr_pkg::ST_IDLE;
        endcase
    end

    // port outputs
    always_comb
    begin
        request.ready      = (state_reg == csbr_pkg::ST_IDLE);
        cfg.ready          = 1'b1;
        response.valid     = out_valid_reg;
        response.rotated_x = out_x_reg;
        response.rotated_y = out_y_reg;
        response.rotated_z = out_z_reg;
    end

    // control, kept state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= csbr_pkg::ST_IDLE;
            phase_reg     <= csbr_pkg::PH_CR;
            nsel_reg      <= 1'b0;
            mv_idx_reg    <= '0;
            k_reg         <= '0;
            t_reg         <= '0;
            dv_bit_reg    <= '0;
            out_valid_reg <= 1'b0;
            rate_reg      <= RATE_W'(5);
            up_reg[0]     <= '0;
            up_reg[1]     <= '0;
            up_reg[2]     <= UP_W'(65536);
            for (int i = 0; i < 3; i++)
            begin
                cam_reg[i] <= '0;
            end
            look_reg[0]   <= '0;
            look_reg[1]   <= LOOK_Y_RESET;
            look_reg[2]   <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    csbr_pkg::CFG_SMOOTH_RATE: rate_reg  <= cfg.data[RATE_W-1:0];
                    csbr_pkg::CFG_UP_X:        up_reg[0] <= $signed(cfg.data);
                    csbr_pkg::CFG_UP_Y:        up_reg[1] <= $signed(cfg.data);
                    csbr_pkg::CFG_UP_Z:        up_reg[2] <= $signed(cfg.data);
                    default:                   rate_reg  <= rate_reg;
                endcase
            end

            if (response.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                csbr_pkg::ST_IDLE:
                    if (in_fire)
                    begin
                        mv_idx_reg <= '0;
                        nsel_reg   <= 1'b0;
                        k_reg      <= '0;
                        t_reg      <= '0;
                    end
                csbr_pkg::ST_MV_UPD:
                begin
                    if (mv_idx_reg < 3'd3)
                        cam_reg[mv_idx_reg[1:0]] <= mv_new;
                    else
                        look_reg[2'(mv_idx_reg - 3'd3)] <= mv_new;
                    mv_idx_reg <= mv_idx_reg + 3'd1;
                end
                csbr_pkg::ST_NM_MAX:
                begin
                    k_reg <= '0;
                    t_reg <= '0;
                    if (mag_max == '0)
                        phase_reg <= nsel_reg ? csbr_pkg::PH_U : csbr_pkg::PH_CR;
                end
                csbr_pkg::ST_NM_SQ_ACC:
                    k_reg <= csbr_pkg::mod3_inc(k_reg);
                csbr_pkg::ST_DV_INIT:
                    dv_bit_reg <= 5'd30;
                csbr_pkg::ST_DV_STEP:
                    dv_bit_reg <= dv_bit_reg - 5'd1;
                csbr_pkg::ST_DV_DONE:
                begin
                    k_reg <= csbr_pkg::mod3_inc(k_reg);
                    t_reg <= '0;
                    if (k_reg == 2'd2)
                        phase_reg <= nsel_reg ? csbr_pkg::PH_U : csbr_pkg::PH_CR;
                end
                csbr_pkg::ST_DOT_ACC:
                    if (!t_last)
                        t_reg <= t_reg + 2'd1;
                csbr_pkg::ST_DOT_DONE:
                begin
                    t_reg <= '0;
                    k_reg <= csbr_pkg::mod3_inc(k_reg);
                    if (k_reg == 2'd2)
                    begin
                        case (phase_reg)
                            csbr_pkg::PH_CR: nsel_reg  <= 1'b1;
                            csbr_pkg::PH_U:  phase_reg <= csbr_pkg::PH_OUT;
                            default:         nsel_reg  <= nsel_reg;
                        endcase
                    end
                end
                csbr_pkg::ST_EMIT:
                    if (out_free)
                        out_valid_reg <= 1'b1;
                default:
                    k_reg <= k_reg;
            endcase
        end
    end

    // working values and payload
    always_ff @(posedge clk)
    begin
        case (state_reg)
            csbr_pkg::ST_IDLE:
                if (in_fire)
                begin
                    tgt_c_reg[0] <= request.cam_target_x;
                    tgt_c_reg[1] <= request.cam_target_y;
                    tgt_c_reg[2] <= request.cam_target_z;
                    tgt_l_reg[0] <= request.look_target_x;
                    tgt_l_reg[1] <= request.look_target_y;
                    tgt_l_reg[2] <= request.look_target_z;
                    dir_reg[0]   <= request.dir_x;
                    dir_reg[1]   <= request.dir_y;
                    dir_reg[2]   <= request.dir_z;
                    gain_reg     <= (gain_raw > 20'(csbr_pkg::GAIN_ONE)) ?
                                    csbr_pkg::GAIN_ONE : gain_raw[GAIN_W-1:0];
                    // view vector magnitudes for the first normalize
                    for (int i = 0; i < 3; i++)
                    begin
                        neg_reg[i] <= diff[i][33];
                        mag_reg[i] <= diff[i][33] ? MAG_W'(-diff[i]) : MAG_W'(diff[i]);
                    end
                end
            csbr_pkg::ST_MV_MUL:
                prod_reg <= mul_p;
            csbr_pkg::ST_NM_MAX:
            begin
                m_reg   <= mag_max;
                acc_reg <= '0;
                if (mag_max == '0)
                begin
                    // zero-length vector normalizes to zero
                    for (int i = 0; i < 3; i++)
                    begin
                        if (nsel_reg)
                            s_reg[i] <= '0;
                        else
                            f_reg[i] <= '0;
                    end
                end
            end
            csbr_pkg::ST_NM_SHIFT:
                if (m_reg[MAG_W-1:UNIT_BITS] != '0)
                begin
                    m_reg <= m_reg >> 1;
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end
                end
                else if (!m_reg[UNIT_BITS-1])
                begin
                    m_reg <= m_reg << 1;
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= mag_reg[i] << 1;
                    end
                end
            csbr_pkg::ST_NM_SQ_MUL:
                prod_reg <= mul_p;
            csbr_pkg::ST_NM_SQ_ACC:
            begin
                acc_reg <= acc_reg + prod_ext;
                if (k_reg == 2'd2)
                begin
                    sq_x_reg   <= 62'(acc_reg + prod_ext);
                    sq_res_reg <= '0;
                    sq_bit_reg <= 64'd1 << 62;
                end
            end
            csbr_pkg::ST_SQ_STEP:
            begin
                if (sq_ge)
                    sq_x_reg <= 62'({2'b0, sq_x_reg} - sq_trial);
                sq_res_reg <= sq_res_next;
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            csbr_pkg::ST_DV_INIT:
            begin
                dv_rem_reg <= {2'b0, mag_reg[k_reg][29:0], 30'b0} + {32'b0, len[30:1]};
                dv_q_reg   <= '0;
            end
            csbr_pkg::ST_DV_STEP:
                if (dv_rem_reg >= dv_trial)
                begin
                    dv_rem_reg           <= dv_rem_reg - dv_trial;
                    dv_q_reg[dv_bit_reg] <= 1'b1;
                end
            csbr_pkg::ST_DV_DONE:
            begin
                acc_reg <= '0;
                if (nsel_reg)
                    s_reg[k_reg] <= dv_val;
                else
                    f_reg[k_reg] <= dv_val;
            end
            csbr_pkg::ST_DOT_MUL:
                prod_reg <= mul_p;
            csbr_pkg::ST_DOT_ACC:
                acc_reg <= acc_add;
            csbr_pkg::ST_DOT_DONE:
            begin
                acc_reg <= '0;
                case (phase_reg)
                    csbr_pkg::PH_CR:
                    begin
                        neg_reg[k_reg] <= acc_reg[ACC_W-1];
                        mag_reg[k_reg] <= acc_mag;
                    end
                    csbr_pkg::PH_U:
                        u_reg[k_reg] <= acc_rnd[COORD_W-1:0];
                    default:
                        rot_reg[k_reg] <= csbr_pkg::clamp32(acc_rnd);
                endcase
            end
            csbr_pkg::ST_EMIT:
                if (out_free)
                begin
                    out_x_reg <= rot_reg[0];
                    out_y_reg <= rot_reg[1];
                    out_z_reg <= rot_reg[2];
                end
            default:
                m_reg <= m_reg;
        endcase
    end

endmodule

// ===== rtl/core/csbr_checker.sv =====
`timescale 1ns / 1ps
// port-level checks for the camera smooth and basis rotate core
module csbr_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_ready,
    input  logic                rsp_valid,
    input  logic                rsp_ready,
    input  logic signed [31:0]  rsp_x,
    input  logic signed [31:0]  rsp_y,
    input  logic signed [31:0]  rsp_z
);

    // a result waits until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_x) && $stable(rsp_y) && $stable(rsp_z))
        else $error("response payload changed while stalled");

    // one item at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while an item is in flight");

    // a result only appears once its item has finished
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_ready))
        else $error("response raised while the core was idle");

endmodule

bind camera_smooth_and_basis_rotate_core csbr_checker u_csbr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .rsp_valid (response.valid),
    .rsp_ready (response.ready),
    .rsp_x     (response.rotated_x),
    .rsp_y     (response.rotated_y),
    .rsp_z     (response.rotated_z)
);
